// File: rtl/sip_pkg.sv
// Shared constants and types for the segment intersection point block.
`timescale 1ns / 1ps
package sip_pkg;

   localparam int COORD_BITS_DEF = 24;
   localparam int THRESH_BITS    = 21;
   localparam int FIFO_DEPTH     = 4;

   typedef logic [1:0] status_type;

   localparam status_type STATUS_NONE     = 2'd0;
   localparam status_type STATUS_HIT      = 2'd1;
   localparam status_type STATUS_PARALLEL = 2'd2;

   localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(1);

endpackage

// File: rtl/sip_if.sv
// Valid/ready channel interfaces for segment pairs and crossing results.
`timescale 1ns / 1ps
interface sip_req_if import sip_pkg::*; #(parameter int COORD_BITS = COORD_BITS_DEF);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] ax1;
   logic signed [COORD_BITS-1:0] ay1;
   logic signed [COORD_BITS-1:0] ax2;
   logic signed [COORD_BITS-1:0] ay2;
   logic signed [COORD_BITS-1:0] bx1;
   logic signed [COORD_BITS-1:0] by1;
   logic signed [COORD_BITS-1:0] bx2;
   logic signed [COORD_BITS-1:0] by2;

   modport source (output valid, ax1, ay1, ax2, ay2, bx1, by1, bx2, by2, input ready);
   modport sink (input valid, ax1, ay1, ax2, ay2, bx1, by1, bx2, by2, output ready);
endinterface

interface sip_rsp_if import sip_pkg::*; #(parameter int COORD_BITS = COORD_BITS_DEF);
   logic                         valid;
   logic                         ready;
   status_type                   status;
   logic signed [COORD_BITS-1:0] cross_x;
   logic signed [COORD_BITS-1:0] cross_y;

   modport source (output valid, status, cross_x, cross_y, input ready);
   modport sink (input valid, status, cross_x, cross_y, output ready);
endinterface

// File: rtl/segment_intersection_point.sv
// Segment intersection point: top level with the threshold register, front, queue and back.
//
// A word on req_ch carries the endpoints of two segments A and B. For each accepted
// word one word leaves on rsp_ch with a status (none, hit or parallel) and, on a hit,
// the crossing point truncated toward the first endpoint of A; otherwise the point is zero.
// The threshold register is written through csr_wr_en and csr_wr_data; a pair whose
// determinant magnitude is below it, or is zero, is reported as parallel.
// The front end forms the three determinants, classifies and scales in six pipeline
// stages, the queue holds up to four words, and the back end divides one quotient bit
// per stage over COORD_BITS stages before the result register.
// One word is accepted and one result delivered every cycle while the receiver takes
// results. When the receiver stalls, the back end holds, the queue fills and then the
// front end holds req_ch.ready low. Reset empties every stage and the queue and sets
// the threshold to one.
`timescale 1ns / 1ps
module segment_intersection_point import sip_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [THRESH_BITS-1:0] csr_wr_data,
   sip_req_if.sink                req_ch,
   sip_rsp_if.source              rsp_ch
);

   localparam int CB  = COORD_BITS;
   localparam int NW  = 2 * CB + 2;
   localparam int PQW = NW + CB;
   localparam int WW  = 2 + 2 * CB + 2 + NW + 2 * PQW;

   logic [THRESH_BITS-1:0] thresh_ff;

   logic                   f_valid;
   logic                   q_full;
   logic                   q_empty;
   logic                   q_pop;
   status_type             f_status, b_status;
   logic [CB-1:0]          f_ax1, f_ay1, b_ax1, b_ay1;
   logic                   f_negx, f_negy, b_negx, b_negy;
   logic [NW-1:0]          f_dn, b_dn;
   logic [PQW-1:0]         f_px, f_py, b_px, b_py;
   logic [WW-1:0]          q_wdata, q_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_wr_en) begin
         thresh_ff <= csr_wr_data;
      end
   end

   sip_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .threshold  (thresh_ff),
      .req_ch     (req_ch),
      .out_valid  (f_valid),
      .out_full   (q_full),
      .out_status (f_status),
      .out_ax1    (f_ax1),
      .out_ay1    (f_ay1),
      .out_negx   (f_negx),
      .out_negy   (f_negy),
      .out_dn     (f_dn),
      .out_px     (f_px),
      .out_py     (f_py)
   );

   assign q_wdata = {f_status, f_ax1, f_ay1, f_negx, f_negy, f_dn, f_px, f_py};

   sip_fifo #(.WIDTH(WW), .DEPTH(FIFO_DEPTH)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (f_valid),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   assign {b_status, b_ax1, b_ay1, b_negx, b_negy, b_dn, b_px, b_py} = q_rdata;

   sip_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_avail  (!q_empty),
      .in_pop    (q_pop),
      .in_status (b_status),
      .in_ax1    (b_ax1),
      .in_ay1    (b_ay1),
      .in_negx   (b_negx),
      .in_negy   (b_negy),
      .in_dn     (b_dn),
      .in_px     (b_px),
      .in_py     (b_py),
      .rsp_ch    (rsp_ch)
   );

endmodule

// File: rtl/sip_fifo.sv
// Short queue that decouples the determinant front end from the divider back end.
`timescale 1ns / 1ps
module sip_fifo import sip_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = FIFO_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff;
   logic [AW-1:0]    rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic [AW-1:0]    wr_ptr_in;
   logic [AW-1:0]    rd_ptr_in;
   logic [CW-1:0]    count_in;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign rdata = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// File: rtl/sip_front.sv
// Front end: accepts segment pairs, forms the determinants, classifies and scales.
`timescale 1ns / 1ps
module sip_front import sip_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [THRESH_BITS-1:0]    threshold,
   sip_req_if.sink                   req_ch,
   output logic                      out_valid,
   input  logic                      out_full,
   output status_type                out_status,
   output logic [COORD_BITS-1:0]     out_ax1,
   output logic [COORD_BITS-1:0]     out_ay1,
   output logic                      out_negx,
   output logic                      out_negy,
   output logic [2*COORD_BITS+1:0]   out_dn,
   output logic [3*COORD_BITS+1:0]   out_px,
   output logic [3*COORD_BITS+1:0]   out_py
);

   localparam int CB   = COORD_BITS;
   localparam int DW   = CB + 1;
   localparam int PW   = 2 * DW;
   localparam int DETW = PW + 1;
   localparam int NW   = DETW - 1;
   localparam int LO   = (NW + 1) / 2;
   localparam int HI   = NW - LO;
   localparam int PQW  = NW + CB;
   localparam int CMPW = (DETW > THRESH_BITS) ? DETW : THRESH_BITS;

   logic en;
   logic [6:1] v_ff;

   // Stage 1: coordinate differences.
   logic signed [DW-1:0] e_ff, f_ff, g_ff, h_ff, k_ff, m_ff;
   logic signed [CB-1:0] ax1_1_ff, ay1_1_ff;
   // Stage 2: products.
   logic signed [PW-1:0] p_ef_ff, p_gh_ff, p_kf_ff, p_mh_ff, p_em_ff, p_gk_ff;
   logic signed [DW-1:0] e_2_ff, g_2_ff;
   logic signed [CB-1:0] ax1_2_ff, ay1_2_ff;
   // Stage 3: determinants.
   logic signed [DETW-1:0] d_ff, da_ff, db_ff;
   logic signed [DW-1:0]   e_3_ff, g_3_ff;
   logic signed [CB-1:0]   ax1_3_ff, ay1_3_ff;
   // Stage 4: classification.
   status_type            st_4_ff;
   logic [NW-1:0]         dn_4_ff, num_4_ff;
   logic [CB-1:0]         magx_4_ff, magy_4_ff;
   logic                  negx_4_ff, negy_4_ff;
   logic signed [CB-1:0]  ax1_4_ff, ay1_4_ff;
   // Stage 5: partial products.
   logic [LO+CB-1:0]      pxl_ff, pyl_ff;
   logic [HI+CB-1:0]      pxh_ff, pyh_ff;
   status_type            st_5_ff;
   logic [NW-1:0]         dn_5_ff;
   logic                  negx_5_ff, negy_5_ff;
   logic signed [CB-1:0]  ax1_5_ff, ay1_5_ff;
   // Stage 6: full products.
   logic [PQW-1:0]        px_ff, py_ff;
   status_type            st_6_ff;
   logic [NW-1:0]         dn_6_ff;
   logic                  negx_6_ff, negy_6_ff;
   logic signed [CB-1:0]  ax1_6_ff, ay1_6_ff;

   logic signed [DETW-1:0] dn_in, dan_in, dbn_in;
   logic [DETW-1:0]        absd_in;
   logic                   par_in, hit_in;
   status_type             st_in;
   logic signed [DW-1:0]   magx_in, magy_in;

   assign en           = !(v_ff[6] && out_full);
   assign req_ch.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[5:1], req_ch.valid};
      end
   end

   always_comb begin
      dn_in   = (d_ff < 0) ? -d_ff : d_ff;
      dan_in  = (d_ff < 0) ? -da_ff : da_ff;
      dbn_in  = (d_ff < 0) ? -db_ff : db_ff;
      absd_in = dn_in;
      par_in  = (d_ff == '0) || (CMPW'(absd_in) < CMPW'(threshold));
      hit_in  = (dan_in >= 0) && (dan_in <= dn_in) && (dbn_in >= 0) && (dbn_in <= dn_in);
      if (par_in) begin
         st_in = STATUS_PARALLEL;
      end else if (hit_in) begin
         st_in = STATUS_HIT;
      end else begin
         st_in = STATUS_NONE;
      end
      magx_in = (e_3_ff < 0) ? -e_3_ff : e_3_ff;
      magy_in = (g_3_ff < 0) ? -g_3_ff : g_3_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_ff     <= DW'(req_ch.ax1) - DW'(req_ch.ax2);
         f_ff     <= DW'(req_ch.by2) - DW'(req_ch.by1);
         g_ff     <= DW'(req_ch.ay1) - DW'(req_ch.ay2);
         h_ff     <= DW'(req_ch.bx2) - DW'(req_ch.bx1);
         k_ff     <= DW'(req_ch.ax1) - DW'(req_ch.bx1);
         m_ff     <= DW'(req_ch.ay1) - DW'(req_ch.by1);
         ax1_1_ff <= req_ch.ax1;
         ay1_1_ff <= req_ch.ay1;

         p_ef_ff  <= PW'(e_ff) * PW'(f_ff);
         p_gh_ff  <= PW'(g_ff) * PW'(h_ff);
         p_kf_ff  <= PW'(k_ff) * PW'(f_ff);
         p_mh_ff  <= PW'(m_ff) * PW'(h_ff);
         p_em_ff  <= PW'(e_ff) * PW'(m_ff);
         p_gk_ff  <= PW'(g_ff) * PW'(k_ff);
         e_2_ff   <= e_ff;
         g_2_ff   <= g_ff;
         ax1_2_ff <= ax1_1_ff;
         ay1_2_ff <= ay1_1_ff;

         d_ff     <= DETW'(p_ef_ff) - DETW'(p_gh_ff);
         da_ff    <= DETW'(p_kf_ff) - DETW'(p_mh_ff);
         db_ff    <= DETW'(p_em_ff) - DETW'(p_gk_ff);
         e_3_ff   <= e_2_ff;
         g_3_ff   <= g_2_ff;
         ax1_3_ff <= ax1_2_ff;
         ay1_3_ff <= ay1_2_ff;

         st_4_ff   <= st_in;
         dn_4_ff   <= dn_in[NW-1:0];
         num_4_ff  <= hit_in ? dan_in[NW-1:0] : '0;
         magx_4_ff <= magx_in[CB-1:0];
         magy_4_ff <= magy_in[CB-1:0];
         negx_4_ff <= (e_3_ff > 0);
         negy_4_ff <= (g_3_ff > 0);
         ax1_4_ff  <= ax1_3_ff;
         ay1_4_ff  <= ay1_3_ff;

         pxl_ff    <= (LO+CB)'(num_4_ff[LO-1:0]) * (LO+CB)'(magx_4_ff);
         pyl_ff    <= (LO+CB)'(num_4_ff[LO-1:0]) * (LO+CB)'(magy_4_ff);
         pxh_ff    <= (HI+CB)'(num_4_ff[NW-1:LO]) * (HI+CB)'(magx_4_ff);
         pyh_ff    <= (HI+CB)'(num_4_ff[NW-1:LO]) * (HI+CB)'(magy_4_ff);
         st_5_ff   <= st_4_ff;
         dn_5_ff   <= dn_4_ff;
         negx_5_ff <= negx_4_ff;
         negy_5_ff <= negy_4_ff;
         ax1_5_ff  <= ax1_4_ff;
         ay1_5_ff  <= ay1_4_ff;

         px_ff     <= (PQW'(pxh_ff) << LO) + PQW'(pxl_ff);
         py_ff     <= (PQW'(pyh_ff) << LO) + PQW'(pyl_ff);
         st_6_ff   <= st_5_ff;
         dn_6_ff   <= dn_5_ff;
         negx_6_ff <= negx_5_ff;
         negy_6_ff <= negy_5_ff;
         ax1_6_ff  <= ax1_5_ff;
         ay1_6_ff  <= ay1_5_ff;
      end
   end

   assign out_valid  = v_ff[6] && en;
   assign out_status = st_6_ff;
   assign out_ax1    = ax1_6_ff;
   assign out_ay1    = ay1_6_ff;
   assign out_negx   = negx_6_ff;
   assign out_negy   = negy_6_ff;
   assign out_dn     = dn_6_ff;
   assign out_px     = px_ff;
   assign out_py     = py_ff;

endmodule

// File: rtl/sip_back.sv
// Back end: pipelined restoring division of the scaled products and the result register.
`timescale 1ns / 1ps
module sip_back import sip_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_avail,
   output logic                      in_pop,
   input  status_type                in_status,
   input  logic [COORD_BITS-1:0]     in_ax1,
   input  logic [COORD_BITS-1:0]     in_ay1,
   input  logic                      in_negx,
   input  logic                      in_negy,
   input  logic [2*COORD_BITS+1:0]   in_dn,
   input  logic [3*COORD_BITS+1:0]   in_px,
   input  logic [3*COORD_BITS+1:0]   in_py,
   sip_rsp_if.source                 rsp_ch
);

   localparam int CB  = COORD_BITS;
   localparam int NW  = 2 * CB + 2;
   localparam int PQW = NW + CB;

   logic                 en;
   logic [CB:0]          v_ff;
   status_type           st_ff   [CB+1];
   logic [CB-1:0]        ax1_ff  [CB+1];
   logic [CB-1:0]        ay1_ff  [CB+1];
   logic [CB:0]          negx_ff;
   logic [CB:0]          negy_ff;
   logic [NW-1:0]        dn_ff   [CB+1];
   logic [PQW-1:0]       px_ff   [CB+1];
   logic [PQW-1:0]       py_ff   [CB+1];
   logic [CB-1:0]        qx_ff   [CB+1];
   logic [CB-1:0]        qy_ff   [CB+1];

   logic                 rsp_valid_ff;
   status_type           rsp_status_ff;
   logic [CB-1:0]        rsp_x_ff;
   logic [CB-1:0]        rsp_y_ff;

   assign en     = !(rsp_valid_ff && !rsp_ch.ready);
   assign in_pop = en && in_avail;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_avail;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0]   <= in_status;
         ax1_ff[0]  <= in_ax1;
         ay1_ff[0]  <= in_ay1;
         negx_ff[0] <= in_negx;
         negy_ff[0] <= in_negy;
         dn_ff[0]   <= in_dn;
         px_ff[0]   <= in_px;
         py_ff[0]   <= in_py;
         qx_ff[0]   <= '0;
         qy_ff[0]   <= '0;
      end
   end

   for (genvar s = 0; s < CB; s++) begin : g_div
      localparam int BIT = CB - 1 - s;
      logic [PQW-1:0] dsh_in;
      logic [PQW-1:0] px_in, py_in;
      logic [CB-1:0]  qx_in, qy_in;

      always_comb begin
         dsh_in = PQW'(dn_ff[s]) << BIT;
         px_in  = px_ff[s];
         py_in  = py_ff[s];
         qx_in  = qx_ff[s];
         qy_in  = qy_ff[s];
         if (px_ff[s] >= dsh_in) begin
            px_in      = px_ff[s] - dsh_in;
            qx_in[BIT] = 1'b1;
         end
         if (py_ff[s] >= dsh_in) begin
            py_in      = py_ff[s] - dsh_in;
            qy_in[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s+1] <= 1'b0;
         end else if (en) begin
            v_ff[s+1] <= v_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[s+1]   <= st_ff[s];
            ax1_ff[s+1]  <= ax1_ff[s];
            ay1_ff[s+1]  <= ay1_ff[s];
            negx_ff[s+1] <= negx_ff[s];
            negy_ff[s+1] <= negy_ff[s];
            dn_ff[s+1]   <= dn_ff[s];
            px_ff[s+1]   <= px_in;
            py_ff[s+1]   <= py_in;
            qx_ff[s+1]   <= qx_in;
            qy_ff[s+1]   <= qy_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v_ff[CB];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_status_ff <= st_ff[CB];
         if (st_ff[CB] == STATUS_HIT) begin
            rsp_x_ff <= negx_ff[CB] ? ax1_ff[CB] - qx_ff[CB] : ax1_ff[CB] + qx_ff[CB];
            rsp_y_ff <= negy_ff[CB] ? ay1_ff[CB] - qy_ff[CB] : ay1_ff[CB] + qy_ff[CB];
         end else begin
            rsp_x_ff <= '0;
            rsp_y_ff <= '0;
         end
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.status  = rsp_status_ff;
   assign rsp_ch.cross_x = rsp_x_ff;
   assign rsp_ch.cross_y = rsp_y_ff;

endmodule
